FILE: rtl/core/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Shared constants, widths, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ROWS        = 24;

    localparam int PI_Q13      = 25736;
    localparam int HALF_PI_Q13 = 12868;
    localparam int TWO_PI_Q13  = 51472;
    localparam int GAIN_Q30    = 652032874;

    localparam logic [15:0] CPT_RST = 16'd5719;
    localparam logic [15:0] IWB_RST = 16'd2913;

    localparam int ADDR_W = 3;
    localparam int CNT_W  = 32;
    localparam int HD_W   = 16;
    localparam int DIF_W  = 34;   // sum or difference of two 33-bit deltas
    localparam int MA_W   = 47;   // multiplicand of the serial multiplier
    localparam int MB_W   = 26;   // multiplier, consumed one bit per cycle
    localparam int MP_W   = MA_W + MB_W;
    localparam int T_W    = 49;   // heading sum before the wrap

    typedef enum logic [0:0] {
        REG_CM_PER_TICK    = 1'b0,
        REG_INV_WHEEL_BASE = 1'b1
    } t_reg_idx;

    // atan(2^-i) in Q30
    function automatic logic [29:0] f_atan(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021688;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/ddo_if.sv
// ----------------------------------------------------------------------------
// Odometry channels
// Valid/ready channels for encoder count words and pose words.
// ----------------------------------------------------------------------------
interface ddo_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  left_count;
    logic signed [31:0]  right_count;
    modport source(output valid, left_count, right_count, input ready);
    modport sink(input valid, left_count, right_count, output ready);
endinterface

interface ddo_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [15:0]  heading;
    modport source(output valid, pos_x, pos_y, heading, input ready);
    modport sink(input valid, pos_x, pos_y, heading, output ready);
endinterface

FILE: rtl/core/ddo_smul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed shift-add multiplier that consumes one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_smul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ddo_pkg::MA_W-1:0]   i_a,
    input  logic signed [ddo_pkg::MB_W-1:0]   i_b,
    output logic                              o_done,
    output logic signed [ddo_pkg::MP_W-1:0]   o_prod
);
    localparam int CW = $clog2(ddo_pkg::MB_W);

    logic signed [ddo_pkg::MP_W-1:0] r_acc;
    logic signed [ddo_pkg::MP_W-1:0] r_a;
    logic        [ddo_pkg::MB_W-1:0] r_b;
    logic        [CW-1:0]            r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic signed [ddo_pkg::MP_W-1:0] w_term;

    assign w_term = r_b[0] ? r_a : '0;

    // The top multiplier bit has negative weight, so its partial product is subtracted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_a    <= ddo_pkg::MP_W'(i_a);
                r_b    <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == CW'(ddo_pkg::MB_W - 1)) begin
                    r_acc  <= r_acc - w_term;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc <= r_acc + w_term;
                end
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: rtl/core/ddo_cordic.sv
// ----------------------------------------------------------------------------
// CORDIC rotator
// Iterative cosine and sine of a Q3.13 heading, rounded to Q22.
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ddo_pkg::HD_W-1:0]   i_angle,
    output logic                              o_busy,
    output logic signed [ddo_pkg::MB_W-1:0]   o_cos,
    output logic signed [ddo_pkg::MB_W-1:0]   o_sin
);
    localparam int N    = (STEPS > ddo_pkg::ATAN_ROWS) ? ddo_pkg::ATAN_ROWS : STEPS;
    localparam int CW   = $clog2(N);
    localparam int CORW = 34;

    logic signed [CORW-1:0] r_x, r_y, r_z;
    logic        [CW-1:0]   r_cnt;
    logic                   r_busy;
    logic                   r_flip;

    logic signed [CORW-1:0] w_xs, w_ys, w_at;
    logic signed [16:0]     w_a;
    logic                   w_flip;
    logic signed [CORW-1:0] w_c, w_s, w_cr, w_sr;

    assign w_xs = r_x >>> r_cnt;
    assign w_ys = r_y >>> r_cnt;
    assign w_at = $signed(CORW'(ddo_pkg::f_atan(5'(r_cnt))));

    // Headings beyond a quarter turn are rotated by a half turn and the results negated.
    always_comb begin
        w_a    = 17'(i_angle);
        w_flip = 1'b0;
        if (i_angle > 16'(ddo_pkg::HALF_PI_Q13)) begin
            w_a    = 17'(i_angle) - 17'(ddo_pkg::PI_Q13);
            w_flip = 1'b1;
        end else if (i_angle < -16'(ddo_pkg::HALF_PI_Q13)) begin
            w_a    = 17'(i_angle) + 17'(ddo_pkg::PI_Q13);
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_x    <= CORW'(ddo_pkg::GAIN_Q30);
            r_y    <= '0;
            r_z    <= $signed({w_a, 17'b0});
            r_flip <= w_flip;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
            if (r_cnt == CW'(N - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign w_c  = r_flip ? -r_x : r_x;
    assign w_s  = r_flip ? -r_y : r_y;
    assign w_cr = w_c + CORW'(128);
    assign w_sr = w_s + CORW'(128);

    assign o_busy = r_busy;
    assign o_cos  = ddo_pkg::MB_W'(w_cr >>> 8);
    assign o_sin  = ddo_pkg::MB_W'(w_sr >>> 8);

endmodule

FILE: rtl/core/ddo_wrap.sv
// ----------------------------------------------------------------------------
// Heading wrap
// Bit-serial true modulo of the new heading into one turn, then offset.
// ----------------------------------------------------------------------------
module ddo_wrap (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ddo_pkg::T_W-1:0]    i_t,
    output logic                              o_busy,
    output logic signed [ddo_pkg::HD_W-1:0]   o_heading
);
    localparam int UW = ddo_pkg::T_W - 1;
    localparam int CW = $clog2(UW);
    localparam logic [16:0] M   = 17'(ddo_pkg::TWO_PI_Q13);
    localparam logic [63:0] K64 = (64'd1 << UW) % 64'(ddo_pkg::TWO_PI_Q13);
    localparam logic [16:0] K   = K64[16:0];

    logic [UW-1:0] r_u;
    logic [16:0]   r_r;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    logic [16:0]        w_rr, w_rs;
    logic signed [17:0] w_v, w_fix;

    assign w_rr = {r_r[15:0], r_u[UW-1]};
    assign w_rs = (w_rr >= M) ? (w_rr - M) : w_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_u    <= i_t[UW-1:0];
            r_neg  <= i_t[UW];
            r_r    <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_r <= w_rs;
            r_u <= r_u << 1;
            if (r_cnt == CW'(UW - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // The sign bit weighs minus 2^48, whose residue is folded in after the sweep.
    always_comb begin
        w_v   = $signed({1'b0, r_r}) - (r_neg ? $signed({1'b0, K}) : 18'sd0);
        w_fix = (w_v < 0) ? (w_v + $signed({1'b0, M})) : w_v;
    end

    assign o_busy    = r_busy;
    assign o_heading = ddo_pkg::HD_W'(w_fix - 18'(ddo_pkg::PI_Q13));

endmodule

FILE: rtl/core/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// Differential drive odometry
// Dead-reckoning pose update from cumulative wheel encoder counts.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                 Word
//  i_in     in   valid/ready               left_count, right_count
//  o_out    out  valid/ready               pos_x, pos_y, heading
//  APB      in   psel/penable, pready = 1  cm_per_tick @0, inv_wheel_base @4
//
//  Words pass one at a time through the shared serial multiplier: five
//  products run one after another, and the next word is accepted only once
//  the result has been loaded into the output register. The CORDIC and the
//  48-step heading wrap run beside the multiplier. Reset is synchronous and
//  needs no clearing pass. A new word is taken while the previous result
//  still waits in the output register; a stalled output holds only the
//  final load.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ddo_in_if.sink                        i_in,
    ddo_out_if.source                     o_out,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_STEP  = 8'b0000_0010,
        S_DIFF  = 8'b0000_0100,
        S_DELTA = 8'b0000_1000,
        S_MX    = 8'b0001_0000,
        S_MY    = 8'b0010_0000,
        S_WRAP  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    localparam int PW = ddo_pkg::MP_W;

    t_state r_state;
    logic signed [31:0]               r_last_l, r_last_r, r_px, r_py;
    logic signed [ddo_pkg::HD_W-1:0]  r_hd;
    logic [15:0]                      r_cpt, r_iwb;
    logic signed [ddo_pkg::DIF_W-1:0] r_dif;
    logic signed [40:0]               r_step8;
    logic signed [ddo_pkg::MA_W-1:0]  r_ma;
    logic signed [ddo_pkg::MB_W-1:0]  r_mb;
    logic                             r_mstart, r_cstart, r_wstart;
    logic signed [ddo_pkg::T_W-1:0]   r_wt;
    logic                             r_ovalid;
    logic signed [31:0]               r_ox, r_oy;
    logic signed [ddo_pkg::HD_W-1:0]  r_oh;

    logic                             w_mdone, w_cbusy, w_wbusy, w_cfg_wr, w_in_acc;
    logic signed [PW-1:0]             m_prod;
    logic signed [ddo_pkg::MB_W-1:0]  w_cos, w_sin;
    logic signed [ddo_pkg::HD_W-1:0]  w_whd;
    logic signed [32:0]               w_dl, w_dr;
    logic signed [ddo_pkg::DIF_W-1:0] w_sum, w_dif;
    logic signed [PW-1:0]             w_b9, w_b3, w_b16, w_b22;
    logic signed [PW-1:0]             w_sh9, w_sh3, w_sh16, w_sh22;
    logic signed [31:0]               w_base;
    logic signed [PW:0]               w_nx;
    logic signed [31:0]               w_sat;
    ddo_pkg::t_reg_idx                w_idx;

    ddo_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (w_mdone),
        .o_prod  (m_prod)
    );

    ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_angle (r_hd),
        .o_busy  (w_cbusy),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    ddo_wrap u_wrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_wstart),
        .i_t       (r_wt),
        .o_busy    (w_wbusy),
        .o_heading (w_whd)
    );

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;
    assign w_idx    = ddo_pkg::t_reg_idx'(i_paddr[2]);

    assign w_dl  = 33'(i_in.left_count) - 33'(r_last_l);
    assign w_dr  = 33'(i_in.right_count) - 33'(r_last_r);
    assign w_sum = ddo_pkg::DIF_W'(w_dl) + ddo_pkg::DIF_W'(w_dr);
    assign w_dif = ddo_pkg::DIF_W'(w_dr) - ddo_pkg::DIF_W'(w_dl);

    // Round to nearest with halves upward, then shift.
    assign w_b9   = m_prod + PW'(256);
    assign w_b3   = m_prod + PW'(4);
    assign w_b16  = m_prod + PW'(32768);
    assign w_b22  = m_prod + PW'(2097152);
    assign w_sh9  = w_b9 >>> 9;
    assign w_sh3  = w_b3 >>> 3;
    assign w_sh16 = w_b16 >>> 16;
    assign w_sh22 = w_b22 >>> 22;

    assign w_base = (r_state == S_MX) ? r_px : r_py;
    assign w_nx   = (PW + 1)'(w_sh22) + (PW + 1)'(w_base);

    always_comb begin
        if (w_nx > (PW + 1)'(64'sh7FFF_FFFF)) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_nx < (PW + 1)'(-64'sh8000_0000)) begin
            w_sat = -32'sh8000_0000;
        end else begin
            w_sat = 32'(w_nx);
        end
    end

    always_comb begin
        case (w_idx)
            ddo_pkg::REG_CM_PER_TICK:    o_prdata = 32'(r_cpt);
            ddo_pkg::REG_INV_WHEEL_BASE: o_prdata = 32'(r_iwb);
            default:                     o_prdata = '0;
        endcase
    end

    assign o_pready      = 1'b1;
    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_ovalid;
    assign o_out.pos_x   = r_ox;
    assign o_out.pos_y   = r_oy;
    assign o_out.heading = r_oh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cpt    <= ddo_pkg::CPT_RST;
            r_iwb    <= ddo_pkg::IWB_RST;
            r_last_l <= '0;
            r_last_r <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_hd     <= ddo_pkg::HD_W'(ddo_pkg::HALF_PI_Q13);
            r_mstart <= 1'b0;
            r_cstart <= 1'b0;
            r_wstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            r_cstart <= 1'b0;
            r_wstart <= 1'b0;
            if (w_cfg_wr) begin
                case (w_idx)
                    ddo_pkg::REG_CM_PER_TICK:    r_cpt <= i_pwdata[15:0];
                    ddo_pkg::REG_INV_WHEEL_BASE: r_iwb <= i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_last_l <= i_in.left_count;
                        r_last_r <= i_in.right_count;
                        r_dif    <= w_dif;
                        r_ma     <= ddo_pkg::MA_W'(w_sum);
                        r_mb     <= ddo_pkg::MB_W'(r_cpt);
                        r_mstart <= 1'b1;
                        r_cstart <= 1'b1;
                        r_state  <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (w_mdone) begin
                        r_step8  <= $signed(w_sh9[40:0]);
                        r_ma     <= ddo_pkg::MA_W'(r_dif);
                        r_mb     <= ddo_pkg::MB_W'(r_cpt);
                        r_mstart <= 1'b1;
                        r_state  <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    if (w_mdone) begin
                        r_ma     <= $signed(w_sh3[ddo_pkg::MA_W-1:0]);
                        r_mb     <= ddo_pkg::MB_W'(r_iwb);
                        r_mstart <= 1'b1;
                        r_state  <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    // The heading sum goes to the wrap unit while x and y are formed.
                    if (w_mdone) begin
                        r_wt     <= ddo_pkg::T_W'(r_hd)
                                  + ddo_pkg::T_W'($signed(w_sh16[47:0]))
                                  + ddo_pkg::T_W'(ddo_pkg::PI_Q13);
                        r_wstart <= 1'b1;
                        r_ma     <= ddo_pkg::MA_W'(r_step8);
                        r_mb     <= w_cos;
                        r_mstart <= 1'b1;
                        r_state  <= S_MX;
                    end
                end
                S_MX: begin
                    if (w_mdone) begin
                        r_px     <= w_sat;
                        r_mb     <= w_sin;
                        r_mstart <= 1'b1;
                        r_state  <= S_MY;
                    end
                end
                S_MY: begin
                    if (w_mdone) begin
                        r_py    <= w_sat;
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (!w_wbusy) begin
                        r_hd    <= w_whd;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ox     <= r_px;
                        r_oy     <= r_py;
                        r_oh     <= r_hd;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_STEP))
        else $error("accepted word did not start the multiplier sequence");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((r_hd >= -16'sd25736) && (r_hd <= 16'sd25735)))
        else $error("heading left the wrapped range");

    a_cordic_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DELTA) && w_mdone) |-> !w_cbusy)
        else $error("CORDIC still busy when its result is needed");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_ovalid || o_out.ready))
            |=> (r_ovalid && (r_state == S_IDLE)))
        else $error("finished word was not presented");
`endif

endmodule

FILE: bench/ddo_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry pose scoreboard
// Predicts the pose after each accepted count word and checks pose words
// against the oldest prediction in order.
// ----------------------------------------------------------------------------
class ddo_scoreboard;
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] hd;
    } t_pose;

    t_pose      pending_poses[$];
    logic [15:0] cpt;
    logic [15:0] iwb;
    longint     prev_l, prev_r, px, py, phd;
    int         errors;
    int         checked;
    int         saturated;

    function new();
        errors = 0;
        checked = 0;
        saturated = 0;
        reset_state();
    endfunction

    function void reset_state();
        cpt = ddo_pkg::CPT_RST;
        iwb = ddo_pkg::IWB_RST;
        prev_l = 0;
        prev_r = 0;
        px = 0;
        py = 0;
        phd = ddo_pkg::HALF_PI_Q13;
    endfunction

    function void set_reg(ddo_pkg::t_reg_idx idx, logic [15:0] v);
        if (idx == ddo_pkg::REG_CM_PER_TICK) cpt = v;
        else iwb = v;
    endfunction

    // Round to nearest with halves upward; SystemVerilog >>> on longint is arithmetic already.
    function longint rnd(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            saturated++;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            saturated++;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function void rotate(longint ang, output longint c, output longint s);
        longint x, y, z, xs, ys;
        bit flip;
        int steps;
        flip = 0;
        x = ddo_pkg::GAIN_Q30;
        y = 0;
        if (ang > ddo_pkg::HALF_PI_Q13) begin
            ang -= ddo_pkg::PI_Q13;
            flip = 1;
        end else if (ang < -ddo_pkg::HALF_PI_Q13) begin
            ang += ddo_pkg::PI_Q13;
            flip = 1;
        end
        z = ang <<< 17;
        steps = ddo_pkg::CORDIC_STEPS_DEF > 24 ? 24 : ddo_pkg::CORDIC_STEPS_DEF;
        for (int i = 0; i < steps; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= atan_val(i);
            end else begin
                x += ys;
                y -= xs;
                z += atan_val(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function longint atan_val(int i);
        longint tbl[24] = '{843314857, 497837829, 263043837, 133525159, 67021688,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
            262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128};
        return tbl[i];
    endfunction

    function void note_counts(logic signed [31:0] l, logic signed [31:0] r);
        longint dl, dr, step8, c30, s30, diff, delta, t;
        t_pose p;
        dl = longint'(l) - prev_l;
        dr = longint'(r) - prev_r;
        prev_l = l;
        prev_r = r;
        step8 = rnd((dl + dr) * longint'(cpt), 9);
        rotate(phd, c30, s30);
        px = clamp32(px + rnd(step8 * rnd(c30, 8), 22));
        py = clamp32(py + rnd(step8 * rnd(s30, 8), 22));
        diff = rnd((dr - dl) * longint'(cpt), 3);
        delta = rnd(diff * longint'(iwb), 16);
        t = (phd + delta + ddo_pkg::PI_Q13) % ddo_pkg::TWO_PI_Q13;
        if (t < 0) t += ddo_pkg::TWO_PI_Q13;
        phd = t - ddo_pkg::PI_Q13;
        p.x = px[31:0];
        p.y = py[31:0];
        p.hd = phd[15:0];
        pending_poses.push_back(p);
    endfunction

    task check_pose(logic signed [31:0] x, logic signed [31:0] y,
                    logic signed [15:0] hd);
        t_pose e;
        checked++;
        if (pending_poses.size() == 0) begin
            report("pose word with no prediction waiting");
            return;
        end
        e = pending_poses.pop_front();
        if (x !== e.x) report($sformatf("pos_x %0d, predicted %0d", x, e.x));
        if (y !== e.y) report($sformatf("pos_y %0d, predicted %0d", y, e.y));
        if (hd !== e.hd) report($sformatf("heading %0d, predicted %0d", hd, e.hd));
    endtask

    task report(string msg);
        errors++;
        $display("MISMATCH word %0d: %s", checked, msg);
    endtask
endclass

FILE: bench/differential_drive_odometry_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Drives count words with random gaps and output stalls, writes both
// registers between phases over APB, and checks every pose word.
// ----------------------------------------------------------------------------
module differential_drive_odometry_tb;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_psel = 0, i_penable = 0, i_pwrite = 0;
    logic [ddo_pkg::ADDR_W-1:0] i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    ddo_in_if  cnt_ch();
    ddo_out_if pose_ch();

    differential_drive_odometry dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(cnt_ch.sink), .o_out(pose_ch.source),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata), .o_prdata(o_prdata),
        .o_pready(o_pready)
    );

    ddo_scoreboard pose_board = new();
    bit   calm;        // no idling in the last part
    int   words_sent;
    logic signed [31:0] cur_l, cur_r;

    always #5 i_clk = ~i_clk;

    // Output side: random stall bursts, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pose_ch.valid && pose_ch.ready)
            pose_board.check_pose(pose_ch.pos_x, pose_ch.pos_y, pose_ch.heading);
    end

    initial begin
        int n;
        pose_ch.ready = 0;
        @(negedge i_clk);
        forever begin
            pose_ch.ready <= 1;
            n = calm ? 1 : $urandom_range(1, 12);
            repeat (n) @(negedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                pose_ch.ready <= 0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
        end
    end

    task automatic apb_write(ddo_pkg::t_reg_idx idx, logic [15:0] v);
        @(negedge i_clk);
        i_psel <= 1;
        i_pwrite <= 1;
        i_penable <= 0;
        i_paddr <= ddo_pkg::ADDR_W'(4 * int'(idx));
        i_pwdata <= {16'h0, v};
        @(negedge i_clk);
        i_penable <= 1;
        @(negedge i_clk);
        i_psel <= 0;
        i_penable <= 0;
        i_pwrite <= 0;
        pose_board.set_reg(idx, v);
    endtask

    task automatic send_counts(logic signed [31:0] l, logic signed [31:0] r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            cnt_ch.valid <= 0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        cnt_ch.valid <= 1;
        cnt_ch.left_count <= l;
        cnt_ch.right_count <= r;
        do @(posedge i_clk); while (!cnt_ch.ready);
        pose_board.note_counts(l, r);
        words_sent++;
        cur_l = l;
        cur_r = r;
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        cnt_ch.valid <= 0;
        while (pose_board.pending_poses.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Small wheel motion around the current counts, sometimes large jumps.
    task automatic random_move();
        int dl, dr;
        case ($urandom_range(0, 9))
            0: begin
                send_counts($urandom, $urandom);
                return;
            end
            1: begin
                dl = $urandom_range(0, 4000) - 2000;
                dr = dl;
            end
            default: begin
                dl = $urandom_range(0, 400) - 200;
                dr = $urandom_range(0, 400) - 200;
            end
        endcase
        send_counts(cur_l + dl, cur_r + dr);
    endtask

    initial begin
        logic [15:0] cpts[4] = '{16'hFFFF, 16'd0, 16'd5719, 16'd0};
        logic [15:0] iwbs[4] = '{16'hFFFF, 16'd0, 16'd2913, 16'd0};
        cnt_ch.valid = 0;
        cnt_ch.left_count = 0;
        cnt_ch.right_count = 0;
        calm = 0;
        words_sent = 0;
        cur_l = 0;
        cur_r = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: reset settings, extremes of counts, spin both ways.
        send_counts(0, 0);
        send_counts(100, 100);
        send_counts(100, 300);
        send_counts(-300, 300);
        send_counts(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_counts(32'sh80000000, 32'sh80000000);
        send_counts(32'sh7FFFFFFF, 32'sh80000000);
        send_counts(32'sh80000000, 32'sh7FFFFFFF);
        send_counts(-1, -1);
        send_counts(32'sh55555555, 32'shAAAAAAAA);
        drain();
        // Extreme registers: push position into saturation and wrap heading.
        apb_write(ddo_pkg::REG_CM_PER_TICK, 16'hFFFF);
        apb_write(ddo_pkg::REG_INV_WHEEL_BASE, 16'hFFFF);
        for (int i = 0; i < 8; i++) begin
            send_counts(32'sh7FFFFFFF, 32'sh7FFFFFFF);
            send_counts(32'sh80000000, 32'sh80000000);
        end
        send_counts(0, 1000);
        send_counts(0, -5000);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 4) begin
                apb_write(ddo_pkg::REG_CM_PER_TICK, ph == 3 ? 16'($urandom) : cpts[ph]);
                apb_write(ddo_pkg::REG_INV_WHEEL_BASE, ph == 3 ? 16'($urandom) : iwbs[ph]);
            end else begin
                apb_write(ddo_pkg::REG_CM_PER_TICK, 16'($urandom));
                apb_write(ddo_pkg::REG_INV_WHEEL_BASE, 16'($urandom));
            end
            if (ph == 5) calm = 1;
            repeat (80) random_move();
            drain();
        end

        $display("Sent %0d count words over several register settings, %0d saturating updates.",
                 words_sent, pose_board.saturated);
        if (pose_board.errors == 0 && pose_board.pending_poses.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule
